// ===== design/assert_macros.svh =====
// assertion macros used by the debounced channel table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

// ===== design/dct_pkg.sv =====
// types, constants and codes of the debounced channel table
package dct_pkg;
	localparam int CHANNELS = 128;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int TIME_W = 32;
	localparam int DELAY_W = 16;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd150;
	localparam logic [CNT_W-1:0] CHANNELS_RESET = 8'd102;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd1;

	// operation codes
	localparam logic [1:0] OP_LEVEL = 2'd0;
	localparam logic [1:0] OP_CHANGE = 2'd1;
	localparam logic [1:0] OP_ALIGN = 2'd2;

	// status codes
	localparam logic [1:0] ST_OFF = 2'd0;
	localparam logic [1:0] ST_ON = 2'd1;
	localparam logic [1:0] ST_NOT_READY = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [CH_W-1:0] channel;
		logic raw_level;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic invalid;
	} out_item_t;

	// one table entry per channel
	typedef struct packed {
		logic seen;
		logic level;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{seen: 1'b1, level: 1'b0, stamp: '0};

	typedef struct packed {
		logic en;
		logic [CH_W-1:0] addr;
		entry_t data;
	} tbl_wr_t;
endpackage

// ===== design/debounce_channel_table.sv =====
// debounced channel table top level: registers, pipeline and handshakes
// an accepted item is held in stage one and then in the output register
// throughput: one item per cycle unless the output stalls; the table memory is read
// at accept and written when the item leaves stage one, with the write forwarded to
// a read of the same channel; reset: registers take their reset values at once, every
// channel reads as level off, nothing pending and time zero until it is first written
`include "assert_macros.svh"
module debounce_channel_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dct_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dct_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dct_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dct_pkg::DELAY_W-1:0] cfg_data
);
	import dct_pkg::*;

	logic [DELAY_W-1:0] delay_q;
	logic [CNT_W-1:0] ch_in_use_q;
	logic adv;
	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_q;
	entry_t rd_entry;
	out_item_t result;
	tbl_wr_t eval_wr;
	tbl_wr_t tbl_wr;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			ch_in_use_q <= CHANNELS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELAY: delay_q <= cfg_data;
				REG_CHANNELS: ch_in_use_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output register is free or being emptied
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			out_valid_q <= valid_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv && valid_s1) begin
			out_q <= result;
		end
	end

	// table write only when the item leaves stage one
	always_comb begin
		tbl_wr = eval_wr;
		tbl_wr.en = eval_wr.en && valid_s1 && adv;
	end

	dct_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_valid && adv),
		.rd_addr(in_data.channel),
		.wr(tbl_wr),
		.rd_data(rd_entry)
	);

	dct_eval u_eval (
		.item(item_s1),
		.entry(rd_entry),
		.delay(delay_q),
		.ch_in_use(ch_in_use_q),
		.result(result),
		.wr(eval_wr)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// checks
	`ASSERT_ALWAYS(a_invalid_not_ready,
		!out_valid_q || !out_q.invalid || out_q.status == ST_NOT_READY,
		"invalid result without not-ready status")
	`ASSERT_ALWAYS(a_stall_blocks_input, !(out_valid_q && !out_ready) || !in_ready,
		"input taken while output stalled")
	`ASSERT_ALWAYS(a_write_on_advance, !tbl_wr.en || (valid_s1 && adv),
		"table write without a moving item")
	`ASSERT_NEXT(a_align_reports_level,
		valid_s1 && adv && item_s1.op == OP_ALIGN && !result.invalid,
		out_valid_q && out_q.status != ST_NOT_READY, "align result not a level")
endmodule

// ===== design/dct_table.sv =====
// channel state memory with per-entry valid bits and write forwarding
module dct_table (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [dct_pkg::CH_W-1:0] rd_addr,
	input dct_pkg::tbl_wr_t wr,
	output dct_pkg::entry_t rd_data
);
	import dct_pkg::*;

	entry_t mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	entry_t rd_q;
	logic rd_vld_q;

	// memory write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// valid bits, an entry never written reads as the reset entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// registered read, forwarding a write to the same channel in this cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr) begin
				rd_q <= wr.data;
				rd_vld_q <= 1'b1;
			end else begin
				rd_q <= mem[rd_addr];
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : ENTRY_RESET;
endmodule

// ===== design/dct_eval.sv =====
// debounce rule, change latch and result for one item
module dct_eval (
	input dct_pkg::in_item_t item,
	input dct_pkg::entry_t entry,
	input logic [dct_pkg::DELAY_W-1:0] delay,
	input logic [dct_pkg::CNT_W-1:0] ch_in_use,
	output dct_pkg::out_item_t result,
	output dct_pkg::tbl_wr_t wr
);
	import dct_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic accept_chg;
	logic in_range;
	entry_t upd;

	assign elapsed = item.now_ms - entry.stamp;
	assign accept_chg = (item.raw_level != entry.level)
		&& (elapsed > {{(TIME_W-DELAY_W){1'b0}}, delay});
	assign in_range = {{(CNT_W-CH_W){1'b0}}, item.channel} < ch_in_use;

	// per-op update and status
	always_comb begin
		upd = entry;
		result.status = ST_NOT_READY;
		result.invalid = 1'b0;
		wr.en = 1'b0;
		if (!in_range) begin
			result.invalid = 1'b1;
		end else begin
			unique case (item.op) inside
				OP_ALIGN: begin
					upd.level = item.raw_level;
					upd.stamp = item.now_ms;
					upd.seen = 1'b1;
					result.status = item.raw_level ? ST_ON : ST_OFF;
					wr.en = 1'b1;
				end
				OP_LEVEL, OP_CHANGE: begin
					if (accept_chg) begin
						upd.level = item.raw_level;
						upd.stamp = item.now_ms;
						upd.seen = 1'b0;
					end
					if (item.op == OP_LEVEL) begin
						result.status = upd.level ? ST_ON : ST_OFF;
					end else if (!upd.seen) begin
						upd.seen = 1'b1;
						result.status = upd.level ? ST_ON : ST_OFF;
					end
					wr.en = 1'b1;
				end
				default: begin
					result.status = ST_NOT_READY;
				end
			endcase
		end
		wr.addr = item.channel;
		wr.data = upd;
	end
endmodule

// ===== verif/dct_checker.sv =====
// checker for the debounced channel table: predicts each input transfer and compares results
module dct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input dct_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input dct_pkg::out_item_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [dct_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dct_pkg::DELAY_W-1:0] cfg_data,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import dct_pkg::*;

	// shadow copy of the registers and the channel table
	logic [DELAY_W-1:0] delay_ms;
	logic [CNT_W-1:0] chan_count;
	logic level_tbl [CHANNELS];
	logic seen_tbl [CHANNELS];
	logic [TIME_W-1:0] stamp_tbl [CHANNELS];
	out_item_t result_q [$];

	// apply the lockout rule and the change latch, return the expected result
	function automatic out_item_t debounce_lookup(in_item_t it);
		out_item_t res;
		logic [TIME_W-1:0] elapsed;
		res.status = ST_NOT_READY;
		res.invalid = 1'b0;
		if ({1'b0, it.channel} >= chan_count) begin
			res.invalid = 1'b1;
		end else if (it.op == OP_ALIGN) begin
			level_tbl[it.channel] = it.raw_level;
			stamp_tbl[it.channel] = it.now_ms;
			seen_tbl[it.channel] = 1'b1;
			res.status = it.raw_level ? ST_ON : ST_OFF;
		end else if (it.op == OP_LEVEL || it.op == OP_CHANGE) begin
			// elapsed time wraps modulo 2^32
			elapsed = it.now_ms - stamp_tbl[it.channel];
			if (it.raw_level != level_tbl[it.channel] && elapsed > delay_ms) begin
				stamp_tbl[it.channel] = it.now_ms;
				level_tbl[it.channel] = it.raw_level;
				seen_tbl[it.channel] = 1'b0;
			end
			if (it.op == OP_LEVEL) begin
				res.status = level_tbl[it.channel] ? ST_ON : ST_OFF;
			end else if (!seen_tbl[it.channel]) begin
				seen_tbl[it.channel] = 1'b1;
				res.status = level_tbl[it.channel] ? ST_ON : ST_OFF;
			end
		end
		return res;
	endfunction

	// watch the three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			delay_ms = DELAY_RESET;
			chan_count = CHANNELS_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				level_tbl[i] = 1'b0;
				seen_tbl[i] = 1'b1;
				stamp_tbl[i] = '0;
			end
			result_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// result transfer against the oldest expectation
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result: expected none actual status %0d invalid %0d",
						$time, out_data.status, out_data.invalid);
					mismatches++;
				end else begin
					exp_item = result_q.pop_front();
					if (out_data.status !== exp_item.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, exp_item.status, out_data.status);
						mismatches++;
					end
					if (out_data.invalid !== exp_item.invalid) begin
						$display("%0t: invalid mismatch: expected %0d actual %0d",
							$time, exp_item.invalid, out_data.invalid);
						mismatches++;
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DELAY) begin
					delay_ms = cfg_data;
				end else if (cfg_index == REG_CHANNELS) begin
					chan_count = cfg_data[CNT_W-1:0];
				end
			end
			// input transfer
			if (in_valid && in_ready) begin
				result_q.push_back(debounce_lookup(in_data));
			end
			outstanding = result_q.size();
		end
	end
endmodule

// ===== verif/tb_top.sv =====
// testbench top for the debounced channel table: clock, reset, stimulus and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dct_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DELAY_W-1:0] cfg_data = '0;
	logic gaps_on = 1'b1;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;

	debounce_channel_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dct_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side stalls now and then in bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one input transfer, with an occasional idle burst ahead of it
	task automatic send_item(input logic [1:0] op_code, input logic [CH_W-1:0] chan,
			input logic raw, input logic [TIME_W-1:0] now);
		in_item_t it;
		it.op = op_code;
		it.channel = chan;
		it.raw_level = raw;
		it.now_ms = now;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// one register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// both registers in random order, junk in the unused upper bits of the count
	task automatic set_config(input logic [DELAY_W-1:0] delay, input logic [CNT_W-1:0] count);
		logic [DELAY_W-CNT_W-1:0] junk;
		junk = (DELAY_W-CNT_W)'($urandom);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_DELAY, delay);
			write_reg(REG_CHANNELS, {junk, count});
		end else begin
			write_reg(REG_CHANNELS, {junk, count});
			write_reg(REG_DELAY, delay);
		end
		cfg_valid <= 1'b0;
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random traffic focused on a few neighbouring channels with a creeping clock
	task automatic run_random(input int unsigned n, input logic [DELAY_W-1:0] delay,
			input logic [CNT_W-1:0] count);
		logic [TIME_W-1:0] t;
		logic [CH_W-1:0] base;
		logic [CH_W-1:0] chan;
		logic [1:0] op_code;
		int unsigned stride;
		int unsigned span;
		int unsigned pick;
		int unsigned i;
		t = $urandom;
		span = (count > CHANNELS) ? CHANNELS : count;
		base = (span > 4) ? CH_W'($urandom_range(0, span - 4)) : '0;
		stride = delay / 6 + 2;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				op_code = OP_LEVEL;
			end else if (pick < 75) begin
				op_code = OP_CHANGE;
			end else if (pick < 90) begin
				op_code = OP_ALIGN;
			end else begin
				op_code = OP_UNUSED;
			end
			if ($urandom_range(0, 9) == 0) begin
				chan = CH_W'($urandom);
			end else begin
				chan = CH_W'(base + $urandom_range(0, 3));
			end
			// mostly small forward steps, now and then a jump anywhere
			if ($urandom_range(0, 49) == 0) begin
				t = $urandom;
			end else begin
				t = t + $urandom_range(0, stride);
			end
			send_item(op_code, chan, 1'($urandom_range(0, 1)), t);
		end
	endtask

	// main sequence
	initial begin
		logic [DELAY_W-1:0] d;
		logic [CNT_W-1:0] c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset settings
		send_item(OP_LEVEL, 7'd0, 1'b0, 32'd0);
		// elapsed equal to the delay is still locked out
		send_item(OP_LEVEL, 7'd0, 1'b1, 32'd150);
		send_item(OP_LEVEL, 7'd0, 1'b1, 32'd151);
		// change latch consumed once
		send_item(OP_CHANGE, 7'd0, 1'b1, 32'd152);
		send_item(OP_CHANGE, 7'd0, 1'b1, 32'd153);
		send_item(OP_CHANGE, 7'd0, 1'b0, 32'd200);
		// elapsed time across the wrap of the millisecond counter
		send_item(OP_ALIGN, 7'd1, 1'b1, 32'hFFFF_FFF0);
		send_item(OP_LEVEL, 7'd1, 1'b0, 32'h0000_0086);
		send_item(OP_CHANGE, 7'd1, 1'b0, 32'h0000_0087);
		send_item(OP_UNUSED, 7'd1, 1'b1, 32'h0000_0100);
		// last channel in use and the first ones beyond it
		send_item(OP_LEVEL, 7'd101, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_LEVEL, 7'd102, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_CHANGE, 7'd127, 1'b1, 32'd5);
		send_item(OP_ALIGN, 7'd127, 1'b1, 32'd6);
		send_item(OP_UNUSED, 7'd127, 1'b0, 32'd7);
		// align drops a pending change
		send_item(OP_ALIGN, 7'd101, 1'b0, 32'd0);
		send_item(OP_CHANGE, 7'd101, 1'b0, 32'd5);
		send_item(OP_ALIGN, 7'd2, 1'b0, 32'h5555_AAAA);
		send_item(OP_CHANGE, 7'd2, 1'b1, 32'hAAAA_5555);
		// back to back on one channel
		send_item(OP_LEVEL, 7'd3, 1'b1, 32'd1000);
		send_item(OP_LEVEL, 7'd3, 1'b0, 32'd1000);
		send_item(OP_CHANGE, 7'd3, 1'b0, 32'd1151);
		send_item(OP_LEVEL, 7'd3, 1'b1, 32'd1301);
		send_item(OP_CHANGE, 7'd3, 1'b1, 32'd1302);
		drain();

		// random phases through the register extremes
		set_config(16'd0, 8'd128);
		run_random(130, 16'd0, 8'd128);
		drain();
		set_config(16'hFFFF, 8'd255);
		run_random(130, 16'hFFFF, 8'd255);
		drain();
		set_config(16'd1, 8'd1);
		run_random(130, 16'd1, 8'd1);
		drain();
		set_config(16'd20, 8'd64);
		run_random(130, 16'd20, 8'd64);
		drain();
		set_config(DELAY_RESET, CHANNELS_RESET);
		run_random(130, DELAY_RESET, CHANNELS_RESET);
		drain();
		d = DELAY_W'($urandom);
		c = CNT_W'($urandom);
		set_config(d, c);
		run_random(130, d, c);
		drain();
		set_config(16'd0, 8'd0);
		run_random(40, 16'd0, 8'd0);
		drain();

		// last part without idling on either side
		gaps_on <= 1'b0;
		d = DELAY_W'($urandom_range(0, 60));
		set_config(d, 8'd128);
		run_random(130, d, 8'd128);
		drain();
		repeat (4) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
